@@ hw/rtl/s5e_pkg.sv @@
// Shared types, constants and state encodings of the 5x5 Sobel edge threshold unit.
package s5e_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 13;
    localparam int PIX_W         = 24;
    localparam int LINE_ROWS     = 4;
    localparam int GRAD_W        = 16;
    localparam int DIFF_W        = 12;
    localparam int SQ_W          = 28;
    localparam int RAD_W         = 30;
    localparam int ROOT_W        = 15;
    localparam int REM_W         = 16;
    localparam int ACC_W         = 28;
    localparam int COEF_W        = 13;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [13:0] LIMIT_SCALE = 14'd15000;
    localparam logic [COEF_W-1:0] GRAY_COEF [3] = '{13'd2989, 13'd5870, 13'd1140};
    localparam logic [7:0] EDGE_ON  = 8'd255;
    localparam logic [7:0] EDGE_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_last;
    } pix_out_t;

    typedef struct packed {
        logic [2:0][GRAD_W-1:0] gx;
        logic [2:0][GRAD_W-1:0] gy;
        logic                   last;
    } grad_t;

    typedef struct packed {
        logic  push;
        logic  full;
        logic  pop;
        logic  nonempty;
    } queue_ctl_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOAD,
        F_DIFF,
        F_SUM
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_ADD,
        B_ROOT,
        B_SCALE,
        B_ACC,
        B_EMIT
    } back_state_t;

endpackage

@@ hw/rtl/s5e_front.sv @@
// Front part: pixel counters, line store, 5x5 window and Sobel gradient sums.
module s5e_front
    import s5e_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pix_in_t           in_data,
    input  logic [10:0]       width_cfg,
    input  logic [ROW_W-1:0]  height_cfg,
    input  logic              q_full,
    output logic              q_push,
    output grad_t             q_data
);

    localparam int LINE_LEN  = MAX_WIDTH + 4;
    localparam int ADDR_W    = $clog2(LINE_LEN);
    localparam int COL_W     = $clog2(MAX_WIDTH + 5);
    localparam int LINE_BITS = LINE_ROWS * PIX_W;

    front_state_t state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [ADDR_W-1:0]    addr_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic                 interior_reg;
    logic                 last_reg;
    logic [LINE_BITS-1:0] mem_q_reg;
    logic [LINE_BITS-1:0] line_mem [LINE_LEN];
    logic [4:0][4:0][PIX_W-1:0] win_reg;
    logic signed [DIFF_W-1:0] dx_reg [3][5];
    logic signed [DIFF_W-1:0] dy_reg [3][5];

    logic [13:0] w_eff, h_eff, wp, hp, col_a, row_a, col_n, row_n;
    logic accept;

    assign in_stall = !(state_reg == F_IDLE && !q_full);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        w_eff = 14'(width_cfg);
        if (w_eff == 14'd0)
        begin
            w_eff = 14'd1;
        end
        if (w_eff > 14'(MAX_WIDTH))
        begin
            w_eff = 14'(MAX_WIDTH);
        end
        h_eff = 14'(height_cfg);
        if (h_eff == 14'd0)
        begin
            h_eff = 14'd1;
        end
        if (h_eff > 14'(MAX_HEIGHT))
        begin
            h_eff = 14'(MAX_HEIGHT);
        end
        wp = w_eff + 14'd4;
        hp = h_eff + 14'd4;

        col_a = 14'(col_reg);
        row_a = 14'(row_reg);
        if (col_a >= wp)
        begin
            col_a = 14'd0;
            row_a = row_a + 14'd1;
        end
        if (row_a >= hp)
        begin
            row_a = 14'd0;
        end
        col_n = col_a + 14'd1;
        row_n = row_a;
        if (col_n >= wp)
        begin
            col_n = 14'd0;
            row_n = row_a + 14'd1;
            if (row_n >= hp)
            begin
                row_n = 14'd0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    col_next   = COL_W'(col_n);
                    row_next   = ROW_W'(row_n);
                    state_next = F_LOAD;
                end
            end
            F_LOAD:  state_next = F_DIFF;
            F_DIFF:  state_next = F_SUM;
            F_SUM:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg     <= ADDR_W'(col_a);
            pix_reg      <= in_data;
            interior_reg <= (row_a >= 14'd4) && (col_a >= 14'd4);
            last_reg     <= (row_a == hp - 14'd1) && (col_a == wp - 14'd1);
            mem_q_reg    <= line_mem[ADDR_W'(col_a)];
        end
        if (state_reg == F_LOAD)
        begin
            line_mem[addr_reg] <= {pix_reg, mem_q_reg[LINE_BITS-1:PIX_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (state_reg == F_LOAD)
        begin
            for (int r = 0; r < 5; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r < LINE_ROWS; r++)
            begin
                win_reg[r][4] <= mem_q_reg[r*PIX_W +: PIX_W];
            end
            win_reg[4][4] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_DIFF)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    dx_reg[ch][i] <=
                        ($signed({4'd0, win_reg[i][0][(2-ch)*8 +: 8]})
                       - $signed({4'd0, win_reg[i][4][(2-ch)*8 +: 8]}))
                      + (($signed({4'd0, win_reg[i][1][(2-ch)*8 +: 8]})
                       - $signed({4'd0, win_reg[i][3][(2-ch)*8 +: 8]})) <<< 1);
                    dy_reg[ch][i] <=
                        ($signed({4'd0, win_reg[4][i][(2-ch)*8 +: 8]})
                       - $signed({4'd0, win_reg[0][i][(2-ch)*8 +: 8]}))
                      + (($signed({4'd0, win_reg[3][i][(2-ch)*8 +: 8]})
                       - $signed({4'd0, win_reg[1][i][(2-ch)*8 +: 8]})) <<< 1);
                end
            end
        end
    end

    always_comb
    begin
        logic signed [GRAD_W-1:0] tx [5];
        logic signed [GRAD_W-1:0] ty [5];
        q_data      = '0;
        q_data.last = last_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                tx[i] = GRAD_W'(dx_reg[ch][i]);
                ty[i] = GRAD_W'(dy_reg[ch][i]);
            end
            q_data.gx[ch] = tx[0] + (tx[1] <<< 2) + (tx[2] <<< 2) + (tx[2] <<< 1)
                          + (tx[3] <<< 2) + tx[4];
            q_data.gy[ch] = ty[0] + (ty[1] <<< 2) + (ty[2] <<< 2) + (ty[2] <<< 1)
                          + (ty[3] <<< 2) + ty[4];
        end
    end

    assign q_push = (state_reg == F_SUM) && interior_reg;

endmodule

@@ hw/rtl/s5e_queue.sv @@
// Two-entry request queue between the gradient front and the magnitude back end.
module s5e_queue
    import s5e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grad_t      push_data,
    input  logic       pop,
    output grad_t      pop_data,
    output queue_ctl_t ctl
);

    grad_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign ctl.push     = push;
    assign ctl.pop      = pop;
    assign ctl.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign ctl.nonempty = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !ctl.full)
        else $error("Request pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ctl.nonempty)
        else $error("Request popped from an empty queue.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

endmodule

@@ hw/rtl/s5e_back.sv @@
// Back end: per-channel gradient magnitude, gray weighting, threshold and output register.
module s5e_back
    import s5e_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  grad_t             q_data,
    output logic              q_pop,
    input  logic [CFG_W-1:0]  thresh_cfg,
    output logic              out_valid,
    input  logic              out_stall,
    output pix_out_t          out_data
);

    back_state_t state_reg, state_next;
    grad_t             cur_reg, cur_next;
    logic [1:0]        ch_reg, ch_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [3:0]        step_reg, step_next;
    logic [ACC_W-1:0]  prod_reg, prod_next, acc_reg, acc_next, lim_reg, lim_next;
    logic              out_valid_reg, out_valid_next;
    pix_out_t          out_reg, out_next;

    logic signed [GRAD_W-1:0]   gxs, gys;
    logic signed [2*GRAD_W-1:0] px, py;
    logic [REM_W+1:0]           rem_sh, trial;

    assign gxs    = $signed(cur_reg.gx[ch_reg]);
    assign gys    = $signed(cur_reg.gy[ch_reg]);
    assign px     = gxs * gxs;
    assign py     = gys * gys;
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ch_next        = ch_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        q_pop          = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_data;
                    ch_next    = 2'd0;
                    acc_next   = '0;
                    lim_next   = ACC_W'(thresh_cfg) * ACC_W'(LIMIT_SCALE);
                    state_next = B_SQUARE;
                end
            end
            B_SQUARE:
            begin
                sqx_next   = SQ_W'(unsigned'(px));
                sqy_next   = SQ_W'(unsigned'(py));
                state_next = B_ADD;
            end
            B_ADD:
            begin
                rad_next   = RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(ROOT_W - 1))
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                prod_next  = ACC_W'(root_reg) * ACC_W'(GRAY_COEF[ch_reg]);
                state_next = B_ACC;
            end
            B_ACC:
            begin
                acc_next = acc_reg + prod_reg;
                if (ch_reg == 2'd2)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = B_SQUARE;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.edge_value = (acc_reg > lim_reg) ? EDGE_ON : EDGE_OFF;
                    out_next.frame_last = cur_reg.last;
                    state_next          = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        ch_reg   <= ch_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        lim_reg  <= lim_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/sobel5x5_rgb_edge_threshold_unit.sv @@
// Top level of the 5x5 Sobel RGB edge threshold unit with its configuration registers.
// The front takes a new pixel only after passing the last through its load, diff and sum
// states, and not while the queue is full; border pixels give no request. The back end
// serves each interior pixel's magnitude request by running the shared one-bit-per-cycle
// square root three times, and pops the next request only after emitting its result.
// Reset clears counters, window, queue and output; registers return to 640, 480 and 1600.
module sobel5x5_rgb_edge_threshold_unit
    import s5e_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pix_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pix_out_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [10:0]      width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [CFG_W-1:0] thresh_reg;

    grad_t      push_data, pop_data;
    logic       push, pop;
    queue_ctl_t qctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            thresh_reg <= 13'd1600;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_THRESH: thresh_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    s5e_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .q_full     (qctl.full),
        .q_push     (push),
        .q_data     (push_data)
    );

    s5e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .ctl       (qctl)
    );

    s5e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (qctl.nonempty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .thresh_cfg (thresh_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

@@ tb/sobel5x5_rgb_edge_threshold_unit_test.sv @@
// Self-checking testbench for the 5x5 Sobel RGB edge threshold unit over small padded frames.
module sobel5x5_rgb_edge_threshold_unit_test;
    import s5e_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN = DEF_MAX_WIDTH + 4;
    localparam int CYCLE_LIMIT = 2000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    pix_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    pix_out_t             out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sobel5x5_rgb_edge_threshold_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        pix_in_t  pixel;
        logic     known;
        pix_out_t result;
    } stim_row_t;

    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned thresh_reg;
    logic [23:0] lines [4*LINE_LEN];
    logic [23:0] window [25];
    int unsigned col_cnt;
    int unsigned row_cnt;

    pix_out_t    expected_edges [$];
    int          errors;
    int          sent_count;
    int unsigned cycles;
    int          send_idle_pct;
    int          stall_pct;

    const int kx [25] = '{ 1,  2, 0,  -2, -1,
                           4,  8, 0,  -8, -4,
                           6, 12, 0, -12, -6,
                           4,  8, 0,  -8, -4,
                           1,  2, 0,  -2, -1};
    const int ky [25] = '{-1, -4,  -6, -4, -1,
                          -2, -8, -12, -8, -2,
                           0,  0,   0,  0,  0,
                           2,  8,  12,  8,  2,
                           1,  4,   6,  4,  1};

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned grad_mag(int shift);
        longint gx;
        longint gy;
        int p;
        gx = 0;
        gy = 0;
        for (int i = 0; i < 25; i++)
        begin
            p = (window[i] >> shift) & 8'hFF;
            gx += kx[i] * p;
            gy += ky[i] * p;
        end
        return int_sqrt(gx * gx + gy * gy);
    endfunction

    // Advances the local copy of the line stores and window by one pixel and predicts its result.
    function automatic bit sobel_predict(pix_in_t px, output pix_out_t res);
        int unsigned w;
        int unsigned h;
        int unsigned wp;
        int unsigned hp;
        int unsigned c;
        int unsigned r;
        longint unsigned gray;
        bit produced;
        w = (width_reg < 1) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
        h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        wp = w + 4;
        hp = h + 4;
        if (col_cnt >= wp)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= hp)
            row_cnt = 0;
        c = col_cnt;
        r = row_cnt;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++)
                window[i*5+j] = window[i*5+j+1];
        for (int i = 0; i < 4; i++)
            window[i*5+4] = lines[i*LINE_LEN+c];
        window[24] = px;
        for (int i = 0; i < 3; i++)
            lines[i*LINE_LEN+c] = lines[(i+1)*LINE_LEN+c];
        lines[3*LINE_LEN+c] = px;
        produced = 1'b0;
        res = '0;
        if (r >= 4 && c >= 4)
        begin
            gray = 16 * (2989 * grad_mag(16) + 5870 * grad_mag(8) + 1140 * grad_mag(0));
            res.edge_value = (gray > 64'd240000 * thresh_reg) ? EDGE_ON : EDGE_OFF;
            res.frame_last = (r == hp - 1 && c == wp - 1);
            produced = 1'b1;
        end
        col_cnt = c + 1;
        if (col_cnt >= wp)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= hp)
                row_cnt = 0;
        end
        return produced;
    endfunction

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg  = value & 11'h7FF;
            CFG_HEIGHT: height_reg = value & 13'h1FFF;
            default:    thresh_reg = value & 13'h1FFF;
        endcase
    endtask

    task automatic send_pixel(pix_in_t px, bit known, pix_out_t known_res);
        pix_out_t res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        if (sobel_predict(px, res))
        begin
            if (known && res !== known_res)
            begin
                $display("%0t table row disagrees: expected %h got %h", $time, known_res, res);
                errors++;
            end
            expected_edges.push_back(res);
        end
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(negedge clk);
        repeat (300)
            @(negedge clk);
    endtask

    task automatic random_frame(int unsigned w, int unsigned h, int style);
        pix_in_t px;
        int unsigned we;
        int unsigned he;
        we = (w < 1) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        he = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        for (int i = 0; i < (we + 4) * (he + 4); i++)
        begin
            case (style)
                0: px = 24'($urandom);
                1: px = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
                default: px = (i % (we + 4) < (we + 4) / 2) ? 24'h101010 : 24'hF0E0D0;
            endcase
            send_pixel(px, 1'b0, '0);
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_data);
                errors++;
            end
            else
            begin
                if (out_data.edge_value !== expected_edges[0].edge_value
                    || out_data.frame_last !== expected_edges[0].frame_last)
                begin
                    $display("%0t mismatch: expected %h got %h", $time,
                             expected_edges[0], out_data);
                    errors++;
                end
                void'(expected_edges.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sobel5x5_rgb_edge_threshold_unit verification failed");
            $finish;
        end
    end

    stim_row_t table_rows [$];

    initial
    begin
        stim_row_t row;
        errors = 0;
        cycles = 0;
        sent_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        width_reg = 640;
        height_reg = 480;
        thresh_reg = 1600;
        col_cnt = 0;
        row_cnt = 0;
        foreach (lines[i])
            lines[i] = '0;
        foreach (window[i])
            window[i] = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;

        // A 1x1 image is 25 pixels: a dark field with its two right columns bright gives an edge.
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        write_reg(CFG_THRESH, 0);
        for (int i = 0; i < 25; i++)
        begin
            row.pixel = (i % 5 >= 3) ? 24'hFFFFFF : 24'h000000;
            row.known = (i == 24);
            row.result = '{edge_value: EDGE_ON, frame_last: 1'b1};
            table_rows.push_back(row);
        end
        foreach (table_rows[i])
            send_pixel(table_rows[i].pixel, table_rows[i].known, table_rows[i].result);
        wait_drained();

        // A flat frame never beats even the zero threshold.
        for (int i = 0; i < 25; i++)
            send_pixel(24'hFFFFFF, i == 24, '{edge_value: EDGE_OFF, frame_last: 1'b1});
        wait_drained();

        write_reg(CFG_THRESH, 8191);
        random_frame(1, 1, 1);
        write_reg(CFG_THRESH, 0);
        random_frame(0, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 32 : 76) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 32 : 76) : 0;
            for (int f = 0; f < 5; f++)
            begin
                write_reg(CFG_THRESH, (f == 0) ? 8191 : $urandom_range(3000));
                random_frame($urandom_range(1, 5), $urandom_range(1, 3), f % 3);
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;

        if (errors == 0)
            $display("sobel5x5_rgb_edge_threshold_unit verification clean");
        else
            $display("sobel5x5_rgb_edge_threshold_unit verification failed");
        $finish;
    end

endmodule
